@@ src/akh_pkg.sv @@
// ============================================================================
// akh_pkg: shared constants for the analog key calibration block
// Fixed-point widths, reset values, register indexes and the scale numerator.
// ============================================================================
`default_nettype none

package akh_pkg;

   // configuration register width and indexes
   localparam int CFG_BITS = 12;
   localparam int CSR_IDX_BITS = 2;
   localparam logic [CSR_IDX_BITS-1:0] REG_RELEASE = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_PRESS = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_MIN_SPAN = 2'd2;

   // register reset values
   localparam logic [CFG_BITS-1:0] RELEASE_RESET = 12'd600;
   localparam logic [CFG_BITS-1:0] PRESS_RESET = 12'd1024;
   localparam logic [CFG_BITS-1:0] MIN_SPAN_RESET = 12'd1000;

   // travel fixed point: full travel is 1.0 in q11
   localparam int FRAC_BITS = 11;
   localparam int TRAVEL_BITS = 12;
   localparam logic [TRAVEL_BITS-1:0] FULL_TRAVEL = 12'd2048;

   // scale = 2^SCALE_EXP / span, quotient produced two bits per cycle
   localparam int SCALE_EXP = 2 * FRAC_BITS;
   localparam int QUOT_BITS = 24;
   localparam int QPOS_BITS = 5;
   localparam logic [QUOT_BITS-1:0] UNCAL_SCALE = 24'd2048;

   // bit of the constant numerator at a quotient bit position
   function automatic logic num_bit(input logic [QPOS_BITS-1:0] pos);
      return (pos == QPOS_BITS'(SCALE_EXP));
   endfunction

endpackage

`default_nettype wire

@@ src/akh_div.sv @@
// ============================================================================
// akh_div: iterative divider for the calibration scale
// Restoring division of the constant 2^22 by the key span, two quotient
// bits per cycle.
// ============================================================================
`default_nettype none

module akh_div #(
   parameter int DW = 12
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [DW-1:0]                 divisor,
   output logic                               busy,
   output logic                               done,
   output logic [akh_pkg::QUOT_BITS-1:0]      quotient
);

   localparam int QW = akh_pkg::QUOT_BITS;
   localparam int PB = akh_pkg::QPOS_BITS;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [PB-1:0] pos_ff, pos_in;
   logic [DW:0]   rem_ff, rem_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic [DW-1:0] dvs_ff, dvs_in;

   logic [DW:0]   rem_v;
   logic [DW:0]   trial_v;
   logic [QW-1:0] quo_v;
   logic [PB-1:0] pos_v;
   logic          qbit_v;

   // two restoring steps on the running remainder
   always_comb begin
      rem_v = rem_ff;
      quo_v = quo_ff;
      trial_v = '0;
      pos_v = pos_ff;
      qbit_v = 1'b0;
      for (int j = 0; j < 2; j++) begin
         pos_v = pos_ff - PB'(j);
         trial_v = {rem_v[DW-1:0], akh_pkg::num_bit(pos_v)};
         if (trial_v >= {1'b0, dvs_ff}) begin
            rem_v = trial_v - {1'b0, dvs_ff};
            qbit_v = 1'b1;
         end else begin
            rem_v = trial_v;
            qbit_v = 1'b0;
         end
         quo_v = {quo_v[QW-2:0], qbit_v};
      end
   end

   // sequencing of the iterations
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      pos_in = pos_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         pos_in = PB'(QW - 1);
         rem_in = '0;
         quo_in = '0;
         dvs_in = divisor;
      end else if (busy_ff) begin
         rem_in = rem_v;
         quo_in = quo_v;
         pos_in = pos_ff - PB'(2);
         if (pos_ff == PB'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quotient = quo_ff;

   // a new division only starts on an idle unit
   assert property (@(posedge clock) disable iff (reset) start |-> !busy_ff)
      else $error("divider started while busy");

   // done only ends a running division
   assert property (@(posedge clock) disable iff (reset) done_ff |-> $past(busy_ff))
      else $error("divider done without a running division");

   // two bits per step keep the position odd while running
   assert property (@(posedge clock) disable iff (reset) busy_ff |-> pos_ff[0])
      else $error("divider position out of step");

endmodule

`default_nettype wire

@@ src/analog_key_autocal_hysteresis.sv @@
// ============================================================================
// analog_key_autocal_hysteresis: self-calibrating analog key with hysteresis
// Per-key min/max tracking, scaled travel and press/release decision.
// ============================================================================
// Usage:
// - request channel (req_*): one converter sample for one key of the matrix.
//   A request is taken when req_valid is high and req_stall is low.
// - response channel (rsp_*): exactly one response per request, in order,
//   with pressed state, change flag and travel (0..2048).
// - csr channel: write release threshold (0), press threshold (1) and
//   minimum span (2); csr_ready is always high, write only while idle.
// Sequence: a calibrated key passes through key memory read, the shared
// two-bit-per-cycle divider, scale load, multiply and decision; an
// uncalibrated key skips the divider, and an out-of-matrix key goes from
// the read straight to the decision. One request is in flight at a time, so
// the next request is taken only after the decision step has finished.
// Reset: a clearing pass writes each of the ROWS*COLS key entries to its
// released, uncalibrated state; requests stall during it.
// Receiver stall: the response is held in an output register; the next
// request may be taken and processed, and it waits only at the final step
// until the held response has been taken.
// ============================================================================
`default_nettype none

module analog_key_autocal_hysteresis #(
   parameter int ROWS = 8,
   parameter int COLS = 16,
   parameter int SAMPLE_BITS = 12
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request channel
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [2:0]                           req_key_row,
   input  wire logic [3:0]                           req_key_col,
   input  wire logic [11:0]                          req_sample,
   // response channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_pressed,
   output logic                                      rsp_changed,
   output logic [akh_pkg::TRAVEL_BITS-1:0]           rsp_travel,
   // configuration write channel
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [akh_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  wire logic [akh_pkg::CFG_BITS-1:0]         csr_data
);

   localparam int SW = SAMPLE_BITS;
   localparam int NKEYS = ROWS * COLS;
   localparam int KW = (NKEYS > 1) ? $clog2(NKEYS) : 1;
   localparam int MW = 2 * SW + 1;
   localparam int QW = akh_pkg::QUOT_BITS;
   localparam int PW = QW + SW;
   localparam int TW = akh_pkg::TRAVEL_BITS;
   localparam int CW = akh_pkg::CFG_BITS;
   localparam logic [KW-1:0] LAST_KEY = KW'(NKEYS - 1);
   localparam logic [SW-1:0] SAMPLE_MASK = {SW{1'b1}};
   localparam logic [MW-1:0] CLEAR_WORD = {1'b0, {SW{1'b0}}, SAMPLE_MASK};

   // sequencer states
   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_READ = 3'd2;
   localparam logic [2:0] S_DIV = 3'd3;
   localparam logic [2:0] S_MUL = 3'd4;
   localparam logic [2:0] S_DECIDE = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [KW-1:0] clr_ff, clr_in;
   logic [CW-1:0] rel_thr_ff, rel_thr_in;
   logic [CW-1:0] prs_thr_ff, prs_thr_in;
   logic [CW-1:0] min_span_ff, min_span_in;

   logic [KW-1:0] key_ff, key_in;
   logic [SW-1:0] samp_ff, samp_in;
   logic          oor_ff, oor_in;
   logic [SW-1:0] lo_ff, lo_in;
   logic [SW-1:0] hi_ff, hi_in;
   logic          down_ff, down_in;
   logic [SW-1:0] diff_ff, diff_in;
   logic [QW-1:0] scale_ff, scale_in;
   logic [PW-1:0] prod_ff, prod_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_pressed_ff, rsp_pressed_in;
   logic          rsp_changed_ff, rsp_changed_in;
   logic [TW-1:0] rsp_travel_ff, rsp_travel_in;

   logic [MW-1:0] key_mem_ff [NKEYS];
   logic [MW-1:0] rd_ff;
   logic          wr_en;
   logic [KW-1:0] wr_addr;
   logic [MW-1:0] wr_data;

   logic          req_take;
   logic          in_range;
   logic [KW-1:0] key_idx;
   logic [SW-1:0] rd_lo;
   logic [SW-1:0] rd_hi;
   logic [SW-1:0] new_lo;
   logic [SW-1:0] new_hi;
   logic [SW-1:0] span;
   logic          calib;
   logic          div_start;
   logic          div_busy;
   logic          div_done;
   logic [QW-1:0] div_quo;
   logic [PW-1:0] trav_wide;
   logic [TW-1:0] travel;
   logic          now_down;
   logic          rsp_load;

   // request decode
   assign req_stall = (state_ff != S_IDLE);
   assign req_take = req_valid && !req_stall;
   assign in_range = (32'(req_key_row) < 32'(ROWS)) && (32'(req_key_col) < 32'(COLS));
   assign key_idx = KW'(32'(req_key_row) * 32'(COLS) + 32'(req_key_col));

   // widen the marks with the sample
   assign rd_lo = rd_ff[SW-1:0];
   assign rd_hi = rd_ff[2*SW-1:SW];
   assign new_lo = (samp_ff < rd_lo) ? samp_ff : rd_lo;
   assign new_hi = (samp_ff > rd_hi) ? samp_ff : rd_hi;
   assign span = new_hi - new_lo;
   assign calib = (new_hi > new_lo) && (32'(span) > 32'(min_span_ff));
   assign div_start = (state_ff == S_READ) && !oor_ff && calib;

   // travel clamp and hysteresis
   assign trav_wide = prod_ff >> akh_pkg::FRAC_BITS;
   assign travel = (trav_wide > PW'(akh_pkg::FULL_TRAVEL)) ? akh_pkg::FULL_TRAVEL
                                                           : trav_wide[TW-1:0];
   always_comb begin
      priority if (down_ff && (travel < rel_thr_ff)) begin
         now_down = 1'b0;
      end else if (!down_ff && (travel > prs_thr_ff)) begin
         now_down = 1'b1;
      end else begin
         now_down = down_ff;
      end
   end

   assign rsp_load = (state_ff == S_DECIDE) && (!rsp_valid_ff || !rsp_stall);

   akh_div #(
      .DW(SW)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .divisor(span),
      .busy(div_busy),
      .done(div_done),
      .quotient(div_quo)
   );

   // sequencer and datapath next values
   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      key_in = key_ff;
      samp_in = samp_ff;
      oor_in = oor_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      down_in = down_ff;
      diff_in = diff_ff;
      scale_in = scale_ff;
      prod_in = prod_ff;
      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + KW'(1);
            if (clr_ff == LAST_KEY) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_take) begin
               key_in = key_idx;
               samp_in = SW'(req_sample);
               oor_in = !in_range;
               state_in = S_READ;
            end
         end
         S_READ: begin
            lo_in = new_lo;
            hi_in = new_hi;
            down_in = rd_ff[MW-1];
            diff_in = samp_ff - new_lo;
            if (oor_ff) begin
               state_in = S_DECIDE;
            end else if (calib) begin
               state_in = S_DIV;
            end else begin
               scale_in = akh_pkg::UNCAL_SCALE;
               state_in = S_MUL;
            end
         end
         S_DIV: begin
            if (div_done) begin
               scale_in = div_quo;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in = PW'(scale_ff) * PW'(diff_ff);
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_pressed_in = rsp_pressed_ff;
      rsp_changed_in = rsp_changed_ff;
      rsp_travel_in = rsp_travel_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_pressed_in = oor_ff ? 1'b0 : now_down;
         rsp_changed_in = oor_ff ? 1'b0 : (now_down != down_ff);
         rsp_travel_in = oor_ff ? '0 : travel;
      end
   end

   // configuration writes
   assign csr_ready = 1'b1;
   always_comb begin
      rel_thr_in = rel_thr_ff;
      prs_thr_in = prs_thr_ff;
      min_span_in = min_span_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            akh_pkg::REG_RELEASE: rel_thr_in = csr_data;
            akh_pkg::REG_PRESS: prs_thr_in = csr_data;
            akh_pkg::REG_MIN_SPAN: min_span_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   // key memory write port: clearing pass or write-back
   always_comb begin
      if (state_ff == S_CLEAR) begin
         wr_en = 1'b1;
         wr_addr = clr_ff;
         wr_data = CLEAR_WORD;
      end else begin
         wr_en = rsp_load && !oor_ff;
         wr_addr = key_ff;
         wr_data = {now_down, hi_ff, lo_ff};
      end
   end

   // key memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem_ff[wr_addr] <= wr_data;
      end
      if (req_take) begin
         rd_ff <= key_mem_ff[key_idx];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         rel_thr_ff <= akh_pkg::RELEASE_RESET;
         prs_thr_ff <= akh_pkg::PRESS_RESET;
         min_span_ff <= akh_pkg::MIN_SPAN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rel_thr_ff <= rel_thr_in;
         prs_thr_ff <= prs_thr_in;
         min_span_ff <= min_span_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      key_ff <= key_in;
      samp_ff <= samp_in;
      oor_ff <= oor_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      down_ff <= down_in;
      diff_ff <= diff_in;
      scale_ff <= scale_in;
      prod_ff <= prod_in;
      rsp_pressed_ff <= rsp_pressed_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_travel_ff <= rsp_travel_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pressed = rsp_pressed_ff;
   assign rsp_changed = rsp_changed_ff;
   assign rsp_travel = rsp_travel_ff;

   // a new response only comes from the decision step
   assert property (@(posedge clock) disable iff (reset)
                    $rose(rsp_valid_ff) |-> $past(state_ff == S_DECIDE))
      else $error("response raised outside the decision step");

   // travel never exceeds full scale
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid_ff |-> (rsp_travel_ff <= akh_pkg::FULL_TRAVEL))
      else $error("travel above full scale");

   // the divider only finishes while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset) div_done |-> (state_ff == S_DIV))
      else $error("divider done outside the divide step");

   // the divider is never busy while the sequencer is idle
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == S_IDLE) |-> !div_busy)
      else $error("divider busy while idle");

endmodule

`default_nettype wire
